@@ rtl/cce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int COLOR_W   = 24;
	localparam int GW_W      = 6;
	localparam int GH_W      = 7;
	localparam int PIXX_W    = 18;
	localparam int PIXY_W    = 19;
	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_TDATA_W = 72;

	localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'h1B;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_CMD_C = 8'h63;
	localparam logic [CHAR_W-1:0] CHAR_DIG0  = 8'h30;

	localparam logic [CFG_IDX_W-1:0] REG_PAL0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAL1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAL2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAL3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPHW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPHH = 3'd5;

	localparam logic [COLOR_W-1:0] PAL0_RST = 24'hEFEFEF;
	localparam logic [COLOR_W-1:0] PAL1_RST = 24'hDC143C;
	localparam logic [COLOR_W-1:0] PAL2_RST = 24'h8FBC8F;
	localparam logic [COLOR_W-1:0] PAL3_RST = 24'h1E90FF;
	localparam logic [GW_W-1:0]    GW_RST   = 6'd8;
	localparam logic [GH_W-1:0]    GH_RST   = 7'd16;

	typedef struct packed {
		logic [3:0][COLOR_W-1:0] palette;
		logic [GW_W-1:0]         glyph_width;
		logic [GH_W-1:0]         glyph_height;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] draw_color;
		logic [CHAR_W-1:0]  glyph;
		logic [PIXY_W-1:0]  pixel_y;
		logic [PIXX_W-1:0]  pixel_x;
	} draw_t;

	typedef enum logic [2:0] {
		PH_TEXT  = 3'b001,
		PH_CMD   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

endpackage

`default_nettype wire

@@ rtl/cce_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Configuration register file: palette and glyph cell size.
module cce_cfg
	import cce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palette[0]   <= PAL0_RST;
			cfg_q.palette[1]   <= PAL1_RST;
			cfg_q.palette[2]   <= PAL2_RST;
			cfg_q.palette[3]   <= PAL3_RST;
			cfg_q.glyph_width  <= GW_RST;
			cfg_q.glyph_height <= GH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAL0:   cfg_q.palette[0]   <= cfg_data;
				REG_PAL1:   cfg_q.palette[1]   <= cfg_data;
				REG_PAL2:   cfg_q.palette[2]   <= cfg_data;
				REG_PAL3:   cfg_q.palette[3]   <= cfg_data;
				REG_GLYPHW: cfg_q.glyph_width  <= cfg_data[GW_W-1:0];
				REG_GLYPHH: cfg_q.glyph_height <= cfg_data[GH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/cce_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Escape decoder, cursor state and pixel position for one registered byte.
module cce_core
	import cce_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [CHAR_W-1:0] char_s1,
	input  cfg_t                   cfg,
	output logic                   emit,
	output draw_t                  draw
);

	localparam int PX_PROD_W = COORD_BITS + 8;
	localparam int PY_PROD_W = COORD_BITS + 9;

	phase_t                phase_q, phase_d;
	logic [COLOR_W-1:0]    color_q, color_d;
	logic [COORD_BITS-1:0] col_q, col_d;
	logic [COORD_BITS-1:0] row_q, row_d;

	logic [CHAR_W-1:0]     digit;
	logic [COORD_BITS:0]   col_p1;
	logic [COORD_BITS:0]   row_p1;
	logic [GW_W:0]         w_p1;
	logic [GH_W:0]         h_p1;
	logic [PX_PROD_W-1:0]  prod_x;
	logic [PY_PROD_W-1:0]  prod_y;
	logic [PX_PROD_W+PIXX_W-1:0] ext_x;
	logic [PY_PROD_W+PIXY_W-1:0] ext_y;

	assign digit  = char_s1 - CHAR_DIG0;
	assign col_p1 = {1'b0, col_q} + {{COORD_BITS{1'b0}}, 1'b1};
	assign row_p1 = {1'b0, row_q} + {{COORD_BITS{1'b0}}, 1'b1};
	assign w_p1   = {1'b0, cfg.glyph_width} + {{GW_W{1'b0}}, 1'b1};
	assign h_p1   = {1'b0, cfg.glyph_height} + {{GH_W{1'b0}}, 1'b1};

	// Position uses the cursor before this byte moves it; the +1 is taken
	// before any wrap, so the full counter range plus one can appear.
	assign prod_x = PX_PROD_W'(col_p1) * PX_PROD_W'(w_p1);
	assign prod_y = PY_PROD_W'(row_p1) * PY_PROD_W'(h_p1);
	assign ext_x  = {{PIXX_W{1'b0}}, prod_x};
	assign ext_y  = {{PIXY_W{1'b0}}, prod_y};

	always_comb begin
		phase_d = phase_q;
		color_d = color_q;
		col_d   = col_q;
		row_d   = row_q;
		emit    = 1'b0;
		case (phase_q)
			PH_CMD: begin
				if (char_s1 != CHAR_NUL) begin
					phase_d = (char_s1 == CHAR_CMD_C) ? PH_DIGIT : PH_TEXT;
				end
			end
			PH_DIGIT: begin
				if (digit < 8'd4) begin
					color_d = cfg.palette[digit[1:0]];
				end
				phase_d = PH_TEXT;
			end
			default: begin
				phase_d = PH_TEXT;
				if (char_s1 == CHAR_ESC) begin
					phase_d = PH_CMD;
				end else begin
					emit = 1'b1;
					if (char_s1 == CHAR_LF) begin
						col_d = '0;
						row_d = row_p1[COORD_BITS-1:0];
					end else if (char_s1 == CHAR_CR) begin
						col_d = '0;
					end else if (char_s1 == CHAR_VT) begin
						row_d = row_p1[COORD_BITS-1:0];
					end else begin
						col_d = col_p1[COORD_BITS-1:0];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			color_q <= PAL0_RST;
			col_q   <= '0;
			row_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			color_q <= color_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	assign draw.pixel_x    = ext_x[PIXX_W-1:0];
	assign draw.pixel_y    = ext_y[PIXY_W-1:0];
	assign draw.glyph      = char_s1;
	assign draw.draw_color = color_q;

endmodule

`default_nettype wire

@@ rtl/console_char_cursor_escape_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Console character unit. Each input beat carries one character byte. The
// block tracks a text cursor, the current drawing color and an escape
// sequence ("ESC c d" picks palette color d, 0 to 3; any other command
// byte ends the sequence, a zero byte while waiting for the command is
// skipped). Every byte other than ESC and the bytes of a sequence yields
// one output beat with the glyph, the color and the pixel position
// (cursor + 1) * (glyph size + 1) taken before the cursor moves; LF, CR and
// VT move the cursor as a terminal does, all else steps one column right,
// and the counters wrap at 2^COORD_BITS. An input beat passes through one
// input register and one output register, with the decode and the two
// small multipliers between them. One byte is taken every cycle while the
// output side keeps up; a stalled output beat holds the single byte in the
// input register, and the input stalls only while both registers are full.
// Configuration writes are taken at any cycle but must only be issued while
// the block is idle.
module console_char_cursor_escape_unit
	import cce_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write port; the index follows the register list order.
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COLOR_W-1:0]     cfg_data,
	// Input stream.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [CHAR_W-1:0]      s_tdata,   // [7:0] char_code
	// Output stream.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata    // [17:0] pixel_x, [36:18] pixel_y,
	                                               // [44:37] glyph, [68:45] draw_color,
	                                               // [71:69] zero
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_free;
	logic              advance;
	logic              emit;
	draw_t             draw;
	logic              out_valid_q;
	draw_t             out_q;

	cce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The output register is free when empty or when its beat leaves now.
	assign out_free = !out_valid_q || m_tready;
	// The registered byte is processed once the output register can take
	// its result; bytes that yield nothing go the same way.
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	cce_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.char_s1 (char_s1),
		.cfg     (cfg),
		.emit    (emit),
		.draw    (draw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= draw;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(draw_t)){1'b0}}, out_q};

endmodule

`default_nettype wire

@@ rtl/cce_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the console character unit.
module cce_checker
	import cce_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// A held output beat stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// The input only stalls when the output side is stalled with a full beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// An ESC byte never shows up as a drawn glyph.
	a_no_esc_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:37] != CHAR_ESC))
		else $error("escape byte emitted as glyph");

	// A new output beat never comes straight out of reset.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(!arst_n, 1))
		else $error("output beat straight out of reset");

endmodule

bind console_char_cursor_escape_unit cce_checker u_cce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
